>>> rtl/pwlsi_pkg.sv
`timescale 1ns / 1ps

package pwlsi_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int VALUE_W    = 16;
  localparam int ENTRY_W    = 2 * VALUE_W;
  localparam int OPERAND_W  = VALUE_W + 1;
  localparam int PROD_W     = 2 * OPERAND_W;
  localparam int DIVIDEND_W = 31;
  localparam int DIVISOR_W  = VALUE_W;

  localparam logic [VALUE_W-1:0] ONE_Q15 = 16'h8000;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_FWD  = 2'd1;
  localparam logic [1:0] OP_INV  = 2'd2;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_GAMMA_START = 2'd1;
  localparam logic [1:0] REG_GAMMA_END   = 2'd2;

  function automatic logic [VALUE_W-1:0] sat_one(input logic [VALUE_W-1:0] v);
    sat_one = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

>>> rtl/piecewise_linear_schedule_interp_top.sv
`timescale 1ns / 1ps

// Piecewise-linear schedule interpolator.
// Input stream (s_*): s_tuser carries the opcode (load, forward query, inverse
// query); s_tdata carries the breakpoint slot, time, level and query value.
// A load writes one breakpoint into the table in its accept cycle and gives
// no transaction on the output. A query gives one output transaction: m_tuser
// is the kind (0 forward, 1 inverse), m_tdata the mapped value and the
// scaled gamma. Opcode three is dropped.
// Config: cfg_we/cfg_index/cfg_data write point_count, gamma_start, gamma_end;
// write only while no query is in flight.
// Sequence: s_tready is high only while the sequencer is idle. A query with
// fewer than two points goes straight to the gamma multiply. Otherwise the
// first and then the last breakpoint are read and the query clamped to them,
// else the table is scanned one entry at a time for the upper breakpoint; a
// span that is not positive skips to the gamma multiply, else one shared
// 17x17 multiplier and a bit-serial divider (31-bit dividend) interpolate.
// The result sits in an output register; the next item is taken while it
// waits, but a later query holds in its final state until m_tready frees it.
// Reset (rst, synchronous) clears control and config; table contents are
// undefined until loaded.
module piecewise_linear_schedule_interp_top #(
  parameter int TABLE_DEPTH = pwlsi_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // point_index, point_time, point_level, query_value
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // mapped_value, scaled_gamma
  output logic [0:0]  m_tuser,   // query_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int VW   = pwlsi_pkg::VALUE_W;
  localparam int OW   = pwlsi_pkg::OPERAND_W;
  localparam int PW   = pwlsi_pkg::PROD_W;
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int NCW  = (CNTW > 7) ? CNTW : 7;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_RD_FIRST = 12'b000000000010,
    ST_CK_FIRST = 12'b000000000100,
    ST_RD_LAST  = 12'b000000001000,
    ST_CK_LAST  = 12'b000000010000,
    ST_RD_SCAN  = 12'b000000100000,
    ST_CK_SCAN  = 12'b000001000000,
    ST_MUL      = 12'b000010000000,
    ST_DSTART   = 12'b000100000000,
    ST_DIV      = 12'b001000000000,
    ST_SMUL     = 12'b010000000000,
    ST_FIN      = 12'b100000000000
  } state_t;

  state_t state;

  logic [6:0]           point_count;
  logic signed [VW-1:0] gamma_start;
  logic signed [VW-1:0] gamma_end;

  logic [1:0]    in_opcode;
  logic [5:0]    in_index;
  logic [VW-1:0] in_time;
  logic [VW-1:0] in_level;
  logic [VW-1:0] in_query;

  assign in_opcode = s_tuser;
  assign in_index  = s_tdata[5:0];
  assign in_time   = s_tdata[21:6];
  assign in_level  = s_tdata[37:22];
  assign in_query  = s_tdata[53:38];

  logic [31:0]   pc32;
  logic [31:0]   n32;
  logic [NCW-1:0] n_eff;
  logic [NCW-1:0] nm1;
  logic [31:0]   idx32;

  always_comb begin
    pc32  = 32'(point_count);
    n32   = (pc32 < 32'(TABLE_DEPTH)) ? pc32 : 32'(TABLE_DEPTH);
    n_eff = n32[NCW-1:0];
    nm1   = n_eff - NCW'(1);
    idx32 = 32'(in_index);
  end

  // table: time in the low half, level in the high half
  logic                          ram_we;
  logic [AW-1:0]                 addr;
  logic [pwlsi_pkg::ENTRY_W-1:0] rd_data;
  logic                          s_fire;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign ram_we   = s_fire && (in_opcode == pwlsi_pkg::OP_LOAD) &&
                    (idx32 < 32'(TABLE_DEPTH));

  pwlsi_ram #(
    .WIDTH (pwlsi_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx32[AW-1:0]),
    .wdata ({pwlsi_pkg::sat_one(in_level), pwlsi_pkg::sat_one(in_time)}),
    .raddr (addr),
    .rdata (rd_data)
  );

  logic          kind;
  logic [VW-1:0] q;
  logic [VW-1:0] mapped;
  logic [VW-1:0] prev_key;
  logic [VW-1:0] prev_val;
  logic [VW-1:0] span;
  logic signed [OW-1:0] opa;
  logic signed [OW-1:0] opb;
  logic signed [PW-1:0] prod;

  logic [VW-1:0] cur_key;
  logic [VW-1:0] cur_val;

  assign cur_key = kind ? rd_data[2*VW-1:VW] : rd_data[VW-1:0];
  assign cur_val = kind ? rd_data[VW-1:0] : rd_data[2*VW-1:VW];

  logic signed [OW-1:0] span_s;
  logic signed [OW-1:0] dv_s;
  logic                 scan_more;

  always_comb begin
    span_s    = $signed({1'b0, cur_key}) - $signed({1'b0, prev_key});
    dv_s      = $signed({1'b0, cur_val}) - $signed({1'b0, prev_val});
    scan_more = (32'(addr) + 32'd1 < 32'(n_eff)) && (cur_key < q);
  end

  // shared multiplier
  logic signed [OW-1:0] mul_a;
  logic signed [OW-1:0] mul_b;
  logic [VW-1:0]        norm;

  always_comb begin
    norm = kind ? q : mapped;
    if (state == ST_SMUL) begin
      mul_a = OW'(gamma_end) - OW'(gamma_start);
      mul_b = $signed({1'b0, norm});
    end else begin
      mul_a = opa;
      mul_b = opb;
    end
  end

  // divider on the magnitude of the product
  logic                             div_start;
  logic                             div_done;
  logic [pwlsi_pkg::DIVIDEND_W-1:0] quotient;
  logic                             neg;
  logic [PW-1:0]                    mag;

  assign div_start = (state == ST_DSTART);
  assign neg       = prod[PW-1];
  assign mag       = neg ? PW'(-prod) : PW'(prod);

  pwlsi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag[pwlsi_pkg::DIVIDEND_W-1:0]),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  logic signed [32:0] q_s;
  logic signed [32:0] res;
  logic [VW-1:0]      res_clamped;

  always_comb begin
    q_s = neg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    res = $signed({17'b0, prev_val}) + q_s;
    if (res < 0) begin
      res_clamped = '0;
    end else if (res > $signed({17'b0, pwlsi_pkg::ONE_Q15})) begin
      res_clamped = pwlsi_pkg::ONE_Q15;
    end else begin
      res_clamped = res[VW-1:0];
    end
  end

  // scaled gamma: floor of product >> 15, saturated
  logic signed [PW-16:0] shifted;
  logic signed [PW-14:0] gsum;
  logic [VW-1:0]         gamma_sat;

  always_comb begin
    shifted = prod[PW-1:15];
    gsum    = (PW-13)'(gamma_start) + (PW-13)'(shifted);
    if (gsum > (PW-13)'(32767)) begin
      gamma_sat = 16'h7fff;
    end else if (gsum < -(PW-13)'(32768)) begin
      gamma_sat = 16'h8000;
    end else begin
      gamma_sat = gsum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      gamma_start <= '0;
      gamma_end   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pwlsi_pkg::REG_POINT_COUNT: point_count <= cfg_data[6:0];
        pwlsi_pkg::REG_GAMMA_START: gamma_start <= cfg_data;
        pwlsi_pkg::REG_GAMMA_END:   gamma_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire && (in_opcode == pwlsi_pkg::OP_FWD ||
                         in_opcode == pwlsi_pkg::OP_INV)) begin
            state <= (n_eff < NCW'(2)) ? ST_SMUL : ST_RD_FIRST;
          end
        end
        ST_RD_FIRST: state <= ST_CK_FIRST;
        ST_CK_FIRST: state <= (q <= cur_key) ? ST_SMUL : ST_RD_LAST;
        ST_RD_LAST:  state <= ST_CK_LAST;
        ST_CK_LAST:  state <= (q >= cur_key) ? ST_SMUL : ST_RD_SCAN;
        ST_RD_SCAN:  state <= ST_CK_SCAN;
        ST_CK_SCAN: begin
          if (scan_more) begin
            state <= ST_RD_SCAN;
          end else if (span_s <= 0) begin
            state <= ST_SMUL;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL:    state <= ST_DSTART;
        ST_DSTART: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SMUL;
          end
        end
        ST_SMUL: state <= ST_FIN;
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q      <= pwlsi_pkg::sat_one(in_query);
        mapped <= pwlsi_pkg::sat_one(in_query);
        kind   <= (in_opcode == pwlsi_pkg::OP_INV);
        addr   <= '0;
      end
      ST_CK_FIRST: begin
        mapped   <= cur_val;
        prev_key <= cur_key;
        prev_val <= cur_val;
        addr     <= nm1[AW-1:0];
      end
      ST_CK_LAST: begin
        mapped <= cur_val;
        addr   <= AW'(1);
      end
      ST_CK_SCAN: begin
        mapped <= prev_val;
        if (scan_more) begin
          prev_key <= cur_key;
          prev_val <= cur_val;
          addr     <= addr + AW'(1);
        end else begin
          opa  <= $signed({1'b0, q - prev_key});
          opb  <= dv_s;
          span <= span_s[VW-1:0];
        end
      end
      ST_MUL, ST_SMUL: begin
        prod <= mul_a * mul_b;
      end
      ST_DIV: begin
        if (div_done) begin
          mapped <= res_clamped;
        end
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {gamma_sat, mapped};
          m_tuser <= kind;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && m_tvalid && !m_tready) |=> (state == ST_FIN && m_tvalid))
    else $error("pending result overwritten");

  a_mapped_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:0] <= pwlsi_pkg::ONE_Q15)
    else $error("mapped value above one");

  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_CK_SCAN |-> (32'(addr) < 32'(n_eff) && addr != '0))
    else $error("scan index outside the valid points");
`endif

endmodule

>>> rtl/pwlsi_ram.sv
`timescale 1ns / 1ps

module pwlsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pwlsi_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module pwlsi_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [pwlsi_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [pwlsi_pkg::DIVISOR_W-1:0]  divisor,
  output logic                             done,
  output logic [pwlsi_pkg::DIVIDEND_W-1:0] quotient
);

  localparam int NW    = pwlsi_pkg::DIVIDEND_W;
  localparam int DW    = pwlsi_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    rem_next;
  logic [NW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             fits;

  always_comb begin
    shifted  = {rem, quo[NW-1]};
    diff     = shifted - {1'b0, divisor};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = pwlsi_pkg::TABLE_DEPTH_DEF;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_INV = 1'b1;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEMS_PER_SEGMENT = 500;

  typedef struct packed {
    logic        kind;
    logic [15:0] mapped;
    logic [15:0] scaled;
  } pwl_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  op;
    logic [5:0]  idx;
    logic [15:0] t_val;
    logic [15:0] l_val;
    logic [15:0] q_val;
    logic        typed;
    pwl_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0]        time_pts [DEPTH];
  logic [15:0]        level_pts [DEPTH];
  logic [6:0]         point_count_q;
  logic signed [15:0] gamma_lo_q;
  logic signed [15:0] gamma_hi_q;

  pwl_result_t expected_results[$];
  stim_row_t   directed_rows[$];

  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  piecewise_linear_schedule_interp_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    pwl_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: kind %0d mapped %0d scaled %0d",
               m_tuser[0], m_tdata[15:0], $signed(m_tdata[31:16]));
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser[0] !== want.kind) begin
          $error("query_kind: expected %0d, got %0d", want.kind, m_tuser[0]);
          fail_count++;
        end
        if (m_tdata[15:0] !== want.mapped) begin
          $error("mapped_value: expected %0d, got %0d", want.mapped, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tdata[31:16] !== want.scaled) begin
          $error("scaled_gamma: expected %0d, got %0d",
                 $signed(want.scaled), $signed(m_tdata[31:16]));
          fail_count++;
        end
      end
    end
  end

  function automatic logic [15:0] cap_q15(input logic [15:0] v);
    return (v > pwlsi_pkg::ONE_Q15) ? pwlsi_pkg::ONE_Q15 : v;
  endfunction

  function automatic longint key_of(input bit inv, input int i);
    return inv ? longint'(level_pts[i]) : longint'(time_pts[i]);
  endfunction

  function automatic longint val_of(input bit inv, input int i);
    return inv ? longint'(time_pts[i]) : longint'(level_pts[i]);
  endfunction

  function automatic logic [15:0] pwl_map(input bit inv, input logic [15:0] qc);
    int n;
    int hi;
    longint qv;
    longint span;
    longint res;
    n = (point_count_q < DEPTH) ? int'(point_count_q) : DEPTH;
    if (n < 2) return qc;
    qv = longint'(qc);
    if (qv <= key_of(inv, 0)) return 16'(val_of(inv, 0));
    if (qv >= key_of(inv, n - 1)) return 16'(val_of(inv, n - 1));
    hi = 1;
    while (hi + 1 < n && key_of(inv, hi) < qv) hi++;
    span = key_of(inv, hi) - key_of(inv, hi - 1);
    res = val_of(inv, hi - 1);
    if (span > 0)
      res += (qv - key_of(inv, hi - 1)) * (val_of(inv, hi) - val_of(inv, hi - 1)) / span;
    if (res < 0) res = 0;
    if (res > 32768) res = 32768;
    return 16'(res);
  endfunction

  function automatic logic [15:0] scale_level(input logic [15:0] nrm);
    longint nv;
    longint p;
    longint qq;
    longint r;
    nv = nrm;
    p = (longint'(gamma_hi_q) - longint'(gamma_lo_q)) * nv;
    qq = (p >= 0) ? p / 32768 : -((-p + 32767) / 32768);
    r = longint'(gamma_lo_q) + qq;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic logic [15:0] pick_gamma();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7FFF;
    if (r < 25) return 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_query(input bit inv, input int used);
    int r;
    r = $urandom_range(99);
    if (r < 15 && used >= 1)
      return 16'(key_of(inv, $urandom_range(used - 1)) + $urandom_range(2) - 1);
    if (r < 25) begin
      case ($urandom_range(2))
        0: return 16'h0000;
        1: return pwlsi_pkg::ONE_Q15;
        default: return 16'hFFFF;
      endcase
    end
    if (r < 40) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(32768));
  endfunction

  function automatic stim_row_t mk_item(input logic [1:0] op, input logic [5:0] idx,
                                        input logic [15:0] t_val, input logic [15:0] l_val,
                                        input logic [15:0] q_val);
    return '{kind: ROW_ITEM, op: op, idx: idx, t_val: t_val, l_val: l_val, q_val: q_val,
             typed: 1'b0, res: '0};
  endfunction

  function automatic stim_row_t mk_check(input logic [1:0] op, input logic [15:0] q_val,
                                         input logic kind, input logic [15:0] mapped,
                                         input logic [15:0] scaled);
    return '{kind: ROW_ITEM, op: op, idx: '0, t_val: '0, l_val: '0, q_val: q_val,
             typed: 1'b1, res: '{kind, mapped, scaled}};
  endfunction

  function automatic stim_row_t mk_reg(input logic [1:0] reg_idx, input logic [15:0] value);
    return '{kind: ROW_CFG, op: reg_idx, idx: '0, t_val: '0, l_val: '0, q_val: value,
             typed: 1'b0, res: '0};
  endfunction

  function automatic void add_row(input stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  task automatic write_reg(input logic [1:0] reg_idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (reg_idx)
      pwlsi_pkg::REG_POINT_COUNT: point_count_q = value[6:0];
      pwlsi_pkg::REG_GAMMA_START: gamma_lo_q = value;
      pwlsi_pkg::REG_GAMMA_END:   gamma_hi_q = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // returns in the step of acceptance with s_tvalid still high
  task automatic push_item(input logic [1:0] op, input logic [5:0] idx,
                           input logic [15:0] t_val, input logic [15:0] l_val,
                           input logic [15:0] q_val, input logic typed,
                           input pwl_result_t typed_res);
    int gap;
    pwl_result_t r;
    logic [15:0] qc;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, q_val, l_val, t_val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    qc = cap_q15(q_val);
    r = '0;
    case (op)
      pwlsi_pkg::OP_LOAD: begin
        time_pts[idx] = cap_q15(t_val);
        level_pts[idx] = cap_q15(l_val);
      end
      pwlsi_pkg::OP_FWD: begin
        r.kind = KIND_FWD;
        r.mapped = pwl_map(1'b0, qc);
        r.scaled = scale_level(r.mapped);
      end
      pwlsi_pkg::OP_INV: begin
        r.kind = KIND_INV;
        r.mapped = pwl_map(1'b1, qc);
        r.scaled = scale_level(qc);
      end
      default: ;
    endcase
    if (op == pwlsi_pkg::OP_FWD || op == pwlsi_pkg::OP_INV)
      expected_results = {expected_results, (typed ? typed_res : r)};
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic run_phase();
    int sel;
    int n_cfg;
    int used;
    int step;
    int t_cur;
    int l_cur;
    int rising;
    int broken;
    int n_q;
    int r;
    int k;
    logic [1:0] op;
    sel = $urandom_range(99);
    if (sel < 8) n_cfg = $urandom_range(1);
    else if (sel < 14) n_cfg = DEPTH;
    else if (sel < 17) n_cfg = 127;
    else n_cfg = $urandom_range(2, 9);
    wait_quiet();
    write_reg(pwlsi_pkg::REG_POINT_COUNT, 16'(n_cfg));
    write_reg(pwlsi_pkg::REG_GAMMA_START, pick_gamma());
    write_reg(pwlsi_pkg::REG_GAMMA_END, pick_gamma());
    used = (n_cfg < DEPTH) ? n_cfg : DEPTH;
    if (used >= 2) begin
      step = 32768 / (used - 1);
      t_cur = $urandom_range(1) ? 0 : $urandom_range(step);
      l_cur = $urandom_range(1) ? 0 : $urandom_range(step);
      rising = $urandom_range(1);
      broken = ($urandom_range(5) == 0);
      for (k = 0; k < used; k++) begin
        if (broken)
          push_item(pwlsi_pkg::OP_LOAD, 6'(k), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'b0, '0);
        else
          push_item(pwlsi_pkg::OP_LOAD, 6'(k), 16'(t_cur),
                    16'(rising ? l_cur : 32768 - l_cur), 16'($urandom), 1'b0, '0);
        t_cur += $urandom_range(2 * step);
        if (t_cur > 32768) t_cur = 32768;
        l_cur += $urandom_range(2 * step);
        if (l_cur > 32768) l_cur = 32768;
      end
    end
    n_q = $urandom_range(20, 60);
    for (k = 0; k < n_q; k++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        push_item(pwlsi_pkg::OP_LOAD, 6'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'b0, '0);
      end else if (r < 11) begin
        push_item(OP_NONE, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'b0, '0);
      end else begin
        op = r[0] ? pwlsi_pkg::OP_FWD : pwlsi_pkg::OP_INV;
        push_item(op, 6'($urandom), 16'($urandom), 16'($urandom),
                  pick_query(op == pwlsi_pkg::OP_INV, used), 1'b0, '0);
      end
    end
  endtask

  initial begin : main_flow
    stim_row_t row;
    int seg;
    point_count_q = '0;
    gamma_lo_q = '0;
    gamma_hi_q = '0;
    for (int i = 0; i < DEPTH; i++) begin
      time_pts[i] = '0;
      level_pts[i] = '0;
    end

    // identity mapping right after reset
    add_row(mk_check(pwlsi_pkg::OP_FWD, 16'h0000, KIND_FWD, 16'h0000, 16'h0000));
    add_row(mk_check(pwlsi_pkg::OP_FWD, 16'hFFFF, KIND_FWD, 16'h8000, 16'h0000));
    add_row(mk_check(pwlsi_pkg::OP_INV, 16'h8000, KIND_INV, 16'h8000, 16'h0000));
    add_row(mk_item(OP_NONE, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // full-range gamma scaling reaches both ends of the signed range
    add_row(mk_reg(pwlsi_pkg::REG_GAMMA_START, 16'h8000));
    add_row(mk_reg(pwlsi_pkg::REG_GAMMA_END, 16'h7FFF));
    add_row(mk_check(pwlsi_pkg::OP_FWD, 16'h8000, KIND_FWD, 16'h8000, 16'h7FFF));
    add_row(mk_check(pwlsi_pkg::OP_INV, 16'h0000, KIND_INV, 16'h0000, 16'h8000));
    add_row(mk_check(pwlsi_pkg::OP_INV, 16'hFFFF, KIND_INV, 16'h8000, 16'h7FFF));
    // falling schedule; entry 3 is oversized and saturates
    add_row(mk_item(pwlsi_pkg::OP_LOAD, 6'd0, 16'h0000, 16'h8000, 16'h0000));
    add_row(mk_item(pwlsi_pkg::OP_LOAD, 6'd1, 16'h4000, 16'h4000, 16'h0000));
    add_row(mk_item(pwlsi_pkg::OP_LOAD, 6'd2, 16'h8000, 16'h0000, 16'h0000));
    add_row(mk_item(pwlsi_pkg::OP_LOAD, 6'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_row(mk_item(pwlsi_pkg::OP_LOAD, 6'd63, 16'h0000, 16'h0000, 16'h0000));
    add_row(mk_reg(pwlsi_pkg::REG_POINT_COUNT, 16'd3));
    add_row(mk_check(pwlsi_pkg::OP_FWD, 16'h0000, KIND_FWD, 16'h8000, 16'h7FFF));
    add_row(mk_check(pwlsi_pkg::OP_FWD, 16'hFFFF, KIND_FWD, 16'h0000, 16'h8000));
    add_row(mk_item(pwlsi_pkg::OP_FWD, 6'd0, 16'h0000, 16'h0000, 16'h2000));
    add_row(mk_item(pwlsi_pkg::OP_FWD, 6'd0, 16'h0000, 16'h0000, 16'h4000));
    add_row(mk_item(pwlsi_pkg::OP_INV, 6'd0, 16'h0000, 16'h0000, 16'h0000));
    add_row(mk_item(pwlsi_pkg::OP_INV, 6'd0, 16'h0000, 16'h0000, 16'h6000));
    add_row(mk_reg(pwlsi_pkg::REG_POINT_COUNT, 16'd1));
    add_row(mk_item(pwlsi_pkg::OP_FWD, 6'd0, 16'h0000, 16'h0000, 16'd1234));
    add_row(mk_reg(pwlsi_pkg::REG_POINT_COUNT, 16'd4));
    add_row(mk_item(pwlsi_pkg::OP_FWD, 6'd0, 16'h0000, 16'h0000, 16'h7000));
    add_row(mk_item(pwlsi_pkg::OP_INV, 6'd0, 16'h0000, 16'h0000, 16'h8000));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 27;
    recv_stall_pct = 45;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_quiet();
        write_reg(row.op, row.q_val);
      end else begin
        push_item(row.op, row.idx, row.t_val, row.l_val, row.q_val, row.typed, row.res);
      end
    end

    items_sent = 0;
    for (seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin send_idle_pct = 27; recv_stall_pct = 45; end
        1: begin send_idle_pct = 45; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      while (items_sent < ITEMS_PER_SEGMENT * (seg + 1)) run_phase();
    end

    wait_quiet();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
